@@ rtl/bvhns_pkg.sv @@
// Package: shared types, constants and helpers for the nearest-entry search block.
`timescale 1ns / 1ps
package bvhns_pkg;

  localparam logic [1:0] FUNC_NODE  = 2'd0;
  localparam logic [1:0] FUNC_ENTRY = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  localparam logic CFG_RADIUS = 1'b0;
  localparam logic CFG_COSLIM = 1'b1;

  localparam int NODE_W  = 158;
  localparam int ENTRY_W = 121;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROOT,
    S_FETCH,
    S_EVAL,
    S_DIST,
    S_CHK,
    S_DOT,
    S_DCHK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clr;
    logic acc_en;
  } mac_ctrl_t;

  function automatic logic [15:0] sat16(input logic signed [23:0] v);
    logic [15:0] r;
    if (v > 24'sd32767) begin
      r = 16'h7fff;
    end else if (v < -24'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/bvhns_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bvhns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

@@ rtl/bvhns_mac.sv @@
// Shared multiply-accumulate unit: registered product, then accumulate.
`timescale 1ns / 1ps
module bvhns_mac
  import bvhns_pkg::*;
(
  input  logic                clk,
  input  mac_ctrl_t           ctrl,
  input  logic signed [24:0]  op_a,
  input  logic signed [24:0]  op_b,
  output logic signed [51:0]  acc
);
  logic signed [49:0] prod_r;
  logic signed [51:0] acc_r;
  logic signed [51:0] acc_nxt;

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.clr) begin
      acc_nxt = '0;
    end else if (ctrl.acc_en) begin
      acc_nxt = acc_r + 52'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    acc_r  <= acc_nxt;
  end

  assign acc = acc_r;
endmodule

@@ rtl/bvh_nearest_entry_search.sv @@
// Top level: tree walk sequencer, node and entry stores, shared MAC.
//
//  Channel | Ports                                  | Transfer
//  --------+----------------------------------------+------------------------
//  input   | start, busy, in_func .. in_link        | start && !busy
//  result  | out_valid, out_found, out_entry_index, | out_valid, one cycle
//          | out_distance_squared                   |
//  config  | cfg_we, cfg_index, cfg_data            | cfg_we
//
// Node and entry writes leave busy low.
// A query walks the tree one node read at a time through the single node read
// port, and tests in-range leaves with the one shared multiplier.
// Reset clears the sequencer and the config registers; the stores hold garbage until written.
// The receiver cannot stall; each result stands for exactly one cycle.
`timescale 1ns / 1ps
module bvh_nearest_entry_search
  import bvhns_pkg::*;
#(
  parameter int MAX_NODES   = 4096,
  parameter int MAX_ENTRIES = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_func,
  input  logic [11:0]         in_address,
  input  logic signed [23:0]  in_coord_a_x,
  input  logic signed [23:0]  in_coord_a_y,
  input  logic signed [23:0]  in_coord_a_z,
  input  logic signed [23:0]  in_coord_b_x,
  input  logic signed [23:0]  in_coord_b_y,
  input  logic signed [23:0]  in_coord_b_z,
  input  logic                in_flag,
  input  logic [12:0]         in_link,
  output logic                out_valid,
  output logic                out_found,
  output logic [11:0]         out_entry_index,
  output logic [49:0]         out_distance_squared,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [49:0]         cfg_data
);
  localparam int NAW = $clog2(MAX_NODES);
  localparam int EAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int EDP = (MAX_ENTRIES > 1) ? MAX_ENTRIES : 2;
  localparam int NW  = NAW + 1;
  localparam int CW  = (NW > 13) ? NW : 13;

  state_t state_r, state_nxt;

  logic [49:0]        radius_r;
  logic signed [15:0] coslim_r;

  logic signed [23:0] qx_r, qy_r, qz_r;
  logic [15:0]        qnx_r, qny_r, qnz_r;
  logic               qflag_r;

  logic [CW-1:0] cur_r, cur_nxt, stop_r, stop_nxt;
  logic [1:0]    sc_r, sc_nxt;
  logic [49:0]   best_r, best_nxt, d2_r, d2_nxt;
  logic [11:0]   idx_r, idx_nxt, eidx_r, eidx_nxt;
  logic          found_r, found_nxt;

  logic                 node_we, node_re, ent_we, ent_re;
  logic [NAW-1:0]       node_raddr;
  logic [NODE_W-1:0]    node_wdata, node_rdata;
  logic [ENTRY_W-1:0]   ent_wdata, ent_rdata;
  logic [EAW-1:0]       ent_raddr;

  mac_ctrl_t          mctl;
  logic signed [24:0] op_a, op_b;
  logic signed [51:0] acc;

  logic accept;
  assign accept = start && !busy;

  // Node word: leaf, link, zmax, zmin, ymax, ymin, xmax, xmin
  assign node_we = accept && in_func == FUNC_NODE && 32'(in_address) < 32'(MAX_NODES);
  assign node_wdata = {in_flag, in_link, in_coord_b_z, in_coord_a_z, in_coord_b_y,
                       in_coord_a_y, in_coord_b_x, in_coord_a_x};
  // Entry word: normal z,y,x, volume, z, y, x
  assign ent_we = accept && in_func == FUNC_ENTRY && 32'(in_address) < 32'(MAX_ENTRIES);
  assign ent_wdata = {sat16(in_coord_b_z), sat16(in_coord_b_y), sat16(in_coord_b_x),
                      in_flag, in_coord_a_z, in_coord_a_y, in_coord_a_x};

  bvhns_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_node_ram (
    .clk(clk), .we(node_we), .waddr(NAW'(in_address)), .wdata(node_wdata),
    .re(node_re), .raddr(node_raddr), .rdata(node_rdata)
  );

  bvhns_ram #(.WIDTH(ENTRY_W), .DEPTH(EDP)) u_entry_ram (
    .clk(clk), .we(ent_we), .waddr(EAW'(in_address)), .wdata(ent_wdata),
    .re(ent_re), .raddr(ent_raddr), .rdata(ent_rdata)
  );

  bvhns_mac u_mac (.clk(clk), .ctrl(mctl), .op_a(op_a), .op_b(op_b), .acc(acc));

  logic signed [23:0] nxmin, nxmax, nymin, nymax, nzmin, nzmax;
  logic               nleaf, inbox, link_ok, ok_base;
  logic [12:0]        nlink;
  logic signed [23:0] ex, ey, ez;
  logic               evol;
  logic [15:0]        enx, eny, enz;
  logic signed [51:0] limit;
  logic [CW-1:0]      nlink_w, root_stop;

  assign {nleaf, nlink, nzmax, nzmin, nymax, nymin, nxmax, nxmin} = node_rdata;
  assign {enz, eny, enx, evol, ez, ey, ex} = ent_rdata;
  assign inbox = qx_r >= nxmin && qx_r <= nxmax && qy_r >= nymin && qy_r <= nymax &&
                 qz_r >= nzmin && qz_r <= nzmax;
  assign link_ok = 32'(nlink) < 32'(MAX_ENTRIES);
  assign nlink_w = CW'(nlink);
  assign root_stop = (32'(nlink) > 32'(MAX_NODES)) ? CW'(MAX_NODES) : nlink_w;
  assign limit = {{22{coslim_r[15]}}, coslim_r, 14'b0};
  assign ok_base = acc[49:0] < best_r && evol == qflag_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept && in_func == FUNC_QUERY) state_nxt = S_ROOT;
      S_ROOT:  state_nxt = S_FETCH;
      S_FETCH: state_nxt = (cur_r < stop_r) ? S_EVAL : S_DONE;
      S_EVAL: begin
        if (nleaf) begin
          state_nxt = link_ok ? S_DIST : S_FETCH;
        end else if (inbox) begin
          state_nxt = S_FETCH;
        end else begin
          state_nxt = (nlink_w <= cur_r) ? S_DONE : S_FETCH;
        end
      end
      S_DIST:  if (sc_r == 2'd3) state_nxt = S_CHK;
      S_CHK:   state_nxt = (ok_base && !qflag_r) ? S_DOT : S_FETCH;
      S_DOT:   if (sc_r == 2'd3) state_nxt = S_DCHK;
      S_DCHK:  state_nxt = S_FETCH;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cur_nxt   = cur_r;
    stop_nxt  = stop_r;
    sc_nxt    = sc_r;
    best_nxt  = best_r;
    idx_nxt   = idx_r;
    eidx_nxt  = eidx_r;
    d2_nxt    = d2_r;
    found_nxt = found_r;
    node_re   = 1'b0;
    node_raddr = NAW'(cur_r);
    ent_re    = 1'b0;
    ent_raddr = EAW'(nlink);
    mctl      = '{clr: (sc_r == 2'd0), acc_en: (sc_r != 2'd0)};
    op_a      = '0;
    op_b      = '0;
    case (state_r)
      S_IDLE: begin
        if (accept && in_func == FUNC_QUERY) begin
          node_re    = 1'b1;
          node_raddr = '0;
          best_nxt   = radius_r;
          idx_nxt    = '0;
          found_nxt  = 1'b0;
        end
      end
      S_ROOT: begin
        cur_nxt  = '0;
        stop_nxt = nleaf ? CW'(1) : root_stop;
      end
      S_FETCH: begin
        node_re = cur_r < stop_r;
        sc_nxt  = '0;
      end
      S_EVAL: begin
        if (nleaf) begin
          ent_re   = link_ok;
          eidx_nxt = nlink[11:0];
          if (!link_ok) cur_nxt = cur_r + CW'(1);
        end else if (inbox) begin
          cur_nxt = cur_r + CW'(1);
        end else begin
          cur_nxt = nlink_w;
        end
      end
      S_DIST: begin
        sc_nxt = sc_r + 2'd1;
        case (sc_r)
          2'd0:    op_a = {qx_r[23], qx_r} - {ex[23], ex};
          2'd1:    op_a = {qy_r[23], qy_r} - {ey[23], ey};
          default: op_a = {qz_r[23], qz_r} - {ez[23], ez};
        endcase
        op_b = op_a;
      end
      S_CHK: begin
        sc_nxt = '0;
        d2_nxt = acc[49:0];
        if (ok_base && qflag_r) begin
          best_nxt  = acc[49:0];
          idx_nxt   = eidx_r;
          found_nxt = 1'b1;
        end
        if (!(ok_base && !qflag_r)) cur_nxt = cur_r + CW'(1);
      end
      S_DOT: begin
        sc_nxt = sc_r + 2'd1;
        case (sc_r)
          2'd0: begin
            op_a = 25'($signed(qnx_r));
            op_b = 25'($signed(enx));
          end
          2'd1: begin
            op_a = 25'($signed(qny_r));
            op_b = 25'($signed(eny));
          end
          default: begin
            op_a = 25'($signed(qnz_r));
            op_b = 25'($signed(enz));
          end
        endcase
      end
      S_DCHK: begin
        cur_nxt = cur_r + CW'(1);
        if (acc > limit) begin
          best_nxt  = d2_r;
          idx_nxt   = eidx_r;
          found_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      radius_r <= '0;
      coslim_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we && cfg_index == CFG_RADIUS) radius_r <= cfg_data;
      if (cfg_we && cfg_index == CFG_COSLIM) coslim_r <= cfg_data[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_func == FUNC_QUERY) begin
      qx_r    <= in_coord_a_x;
      qy_r    <= in_coord_a_y;
      qz_r    <= in_coord_a_z;
      qnx_r   <= sat16(in_coord_b_x);
      qny_r   <= sat16(in_coord_b_y);
      qnz_r   <= sat16(in_coord_b_z);
      qflag_r <= in_flag;
    end
    cur_r   <= cur_nxt;
    stop_r  <= stop_nxt;
    sc_r    <= sc_nxt;
    best_r  <= best_nxt;
    idx_r   <= idx_nxt;
    eidx_r  <= eidx_nxt;
    d2_r    <= d2_nxt;
    found_r <= found_nxt;
  end

  assign busy                 = state_r != S_IDLE;
  assign out_valid            = state_r == S_DONE;
  assign out_found            = found_r;
  assign out_entry_index      = idx_r;
  assign out_distance_squared = best_r;
endmodule

@@ rtl/bvhns_checker.sv @@
// Port-level checker for the nearest-entry search block, with its bind.
`timescale 1ns / 1ps
module bvhns_checker
  import bvhns_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_func,
  input logic        out_valid,
  input logic        out_found,
  input logic [11:0] out_entry_index
);
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside a query");
  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy held after result");
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == FUNC_QUERY) |=> busy && !out_valid)
    else $error("query transfer not taken up");
  a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> out_entry_index == '0)
    else $error("miss with non-zero index");
endmodule

bind bvh_nearest_entry_search bvhns_checker u_bvhns_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_func(in_func),
  .out_valid(out_valid), .out_found(out_found), .out_entry_index(out_entry_index)
);
